// ===== hw/rtl/fsnm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsnm_pkg
// Shared types and constants for the FAT 8.3 short-name entry matcher.
// ----------------------------------------------------------------------------
package fsnm_pkg;

    localparam int QUERY_BYTES = 12;
    localparam int BASE_BYTES  = 8;
    localparam int EXT_BYTES   = 3;

    localparam logic [7:0] CHAR_END    = 8'h00;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_KANJI  = 8'h05;
    localparam logic [7:0] CHAR_FREE   = 8'hE5;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [5:0] ATTR_LFN    = 6'h0F;
    localparam int         ATTR_VOLUME = 3;

    typedef enum logic [2:0] {
        VERDICT_END   = 3'd0,
        VERDICT_SKIP  = 3'd1,
        VERDICT_LABEL = 3'd2,
        VERDICT_MISS  = 3'd3,
        VERDICT_HIT   = 3'd4
    } verdict_t;

    typedef enum logic [1:0] {
        REG_QUERY_LOW    = 2'd0,
        REG_QUERY_HIGH   = 2'd1,
        REG_QUERY_LENGTH = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [QUERY_BYTES-1:0][7:0] bytes;
        logic [3:0]                  length;
    } query_cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fsnm_apb_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsnm_apb_regs
// APB register file holding the query name and its length.
// ----------------------------------------------------------------------------
module fsnm_apb_regs
    import fsnm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    output query_cfg_t       query_cfg
);

    logic [63:0] query_low_reg;
    logic [31:0] query_high_reg;
    logic [3:0]  query_length_reg;
    logic        wr_en;
    reg_index_t  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = reg_index_t'(paddr[4:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_low_reg    <= '0;
            query_high_reg   <= '0;
            query_length_reg <= '0;
        end else if (wr_en) begin
            case (reg_sel)
                REG_QUERY_LOW:    query_low_reg    <= pwdata;
                REG_QUERY_HIGH:   query_high_reg   <= pwdata[31:0];
                REG_QUERY_LENGTH: query_length_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_QUERY_LOW:    prdata = query_low_reg;
            REG_QUERY_HIGH:   prdata = {32'd0, query_high_reg};
            REG_QUERY_LENGTH: prdata = {60'd0, query_length_reg};
            default:          prdata = '0;
        endcase
    end

    assign query_cfg.bytes  = {query_high_reg, query_low_reg};
    assign query_cfg.length = query_length_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/fsnm_classify.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsnm_classify
// Combinational classification of one directory entry against the query.
// ----------------------------------------------------------------------------
module fsnm_classify
    import fsnm_pkg::*;
(
    input  wire logic [63:0] entry_name_low,
    input  wire logic [23:0] entry_name_high,
    input  wire logic [7:0]  entry_attributes,
    input  query_cfg_t       query_cfg,
    output verdict_t         verdict
);

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    function automatic logic [7:0] pick_byte(input logic [QUERY_BYTES-1:0][7:0] b,
                                             input logic [3:0] idx);
        return (idx < 4'(QUERY_BYTES)) ? b[idx] : 8'h00;
    endfunction

    logic [BASE_BYTES-1:0][7:0] base_byte;
    logic [EXT_BYTES-1:0][7:0]  ext_byte;
    logic [7:0]                 first_byte;
    logic [3:0]                 base_len;
    logic [1:0]                 ext_len;
    logic                       base_ok;
    logic                       ext_ok;
    logic [3:0]                 size;
    logic [3:0]                 rem;
    logic                       dot;
    logic                       tail_ok;
    logic                       match;

    assign base_byte = entry_name_low;
    assign ext_byte  = entry_name_high;
    assign size      = query_cfg.length;

    always_comb begin
        base_len = 4'd1;
        for (int i = 1; i < BASE_BYTES; i++) begin
            if (base_byte[i] != CHAR_SPACE) begin
                base_len = 4'(i + 1);
            end
        end
        ext_len = 2'd0;
        for (int j = 0; j < EXT_BYTES; j++) begin
            if (ext_byte[j] != CHAR_SPACE) begin
                ext_len = 2'(j + 1);
            end
        end

        first_byte = (base_byte[0] == CHAR_KANJI) ? CHAR_FREE : base_byte[0];
        base_ok = 1'b1;
        for (int i = 0; i < BASE_BYTES; i++) begin
            if (4'(i) < base_len &&
                upcase(query_cfg.bytes[i]) != upcase((i == 0) ? first_byte : base_byte[i])) begin
                base_ok = 1'b0;
            end
        end

        ext_ok = 1'b1;
        for (int j = 0; j < EXT_BYTES; j++) begin
            if (2'(j) < ext_len &&
                upcase(pick_byte(query_cfg.bytes, base_len + 4'(j) + 4'd1)) !=
                upcase(ext_byte[j])) begin
                ext_ok = 1'b0;
            end
        end

        rem = size - base_len;
        dot = (rem != 4'd0) && (pick_byte(query_cfg.bytes, base_len) == CHAR_DOT);
        if (ext_len != 2'd0) begin
            tail_ok = dot && ({2'd0, ext_len} == rem - 4'd1) && ext_ok;
        end else begin
            tail_ok = (rem == 4'd0) || (dot && rem == 4'd1);
        end

        match = (size != 4'd0) && (size <= 4'(QUERY_BYTES)) &&
                (base_byte[0] != CHAR_SPACE) && (size >= base_len) &&
                base_ok && tail_ok;

        if (base_byte[0] == CHAR_END) begin
            verdict = VERDICT_END;
        end else if (base_byte[0] == CHAR_FREE || entry_attributes[5:0] == ATTR_LFN) begin
            verdict = VERDICT_SKIP;
        end else if (entry_attributes[ATTR_VOLUME]) begin
            verdict = VERDICT_LABEL;
        end else if (match) begin
            verdict = VERDICT_HIT;
        end else begin
            verdict = VERDICT_MISS;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fat_short_name_entry_matcher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fat_short_name_entry_matcher
// Classifies FAT directory entries against an 8.3 query name.
// ----------------------------------------------------------------------------
// The block takes one directory entry beat per cycle while m_tready does not
// stall the output and returns one verdict beat per entry: the entry is held
// in an input register, compared in one pass of combinational logic and the
// verdict is held in a result register, so a full stream runs at one entry per
// cycle. The user sets the query name and its length through the APB port only
// while no entry is in flight; the block itself does not enforce this.
module fat_short_name_entry_matcher
    import fsnm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // entry_name_low [63:0], entry_name_high [87:64], entry_attributes [95:88]
    input  wire logic [95:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // verdict [2:0], zero padding [7:3]
    output logic      [7:0]  m_tdata
);

    query_cfg_t  query_cfg;
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [95:0] in_data_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    verdict_t    verdict_reg;
    verdict_t    verdict;
    logic        in_advance;

    fsnm_apb_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .query_cfg (query_cfg)
    );

    fsnm_classify u_classify (
        .entry_name_low   (in_data_reg[63:0]),
        .entry_name_high  (in_data_reg[87:64]),
        .entry_attributes (in_data_reg[95:88]),
        .query_cfg        (query_cfg),
        .verdict          (verdict)
    );

    assign in_advance = !out_valid_reg || m_tready;
    assign s_tready   = !in_valid_reg || in_advance;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        if (in_advance) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
        if (in_valid_reg && in_advance) begin
            verdict_reg <= verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, verdict_reg};

    a_verdict_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= VERDICT_HIT))
        else $error("verdict code out of range");

    a_hold_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while both registers are full");

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted beat not held in the input register");

    a_end_of_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_advance && in_data_reg[7:0] == CHAR_END)
        |=> (m_tvalid && m_tdata[2:0] == VERDICT_END))
        else $error("end of directory entry not reported");

endmodule
`default_nettype wire
